@@ design/lomc_pkg.sv @@
// shared types, constants and color conversion for the layer ownership compositor
// no dependencies; used by layer_owner_map_compositor_unit

package lomc_pkg;

  // ownership store geometry
  localparam int unsigned MapEntries = 1048576;
  localparam int unsigned DepthBits  = 8;
  localparam int unsigned AddrW      = $clog2(MapEntries);

  // fixed field widths
  localparam int unsigned CoordW = 13;
  localparam int unsigned DepthW = 8;
  localparam int unsigned ColorW = 32;
  localparam int unsigned IndexW = 24;
  localparam int unsigned ProdW  = 25;
  localparam int unsigned SumW   = 26;

  // configuration register indexes
  typedef enum logic [1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegFormat = 2'd2
  } cfg_reg_e;

  // pixel format codes, the other codes emit nothing
  typedef enum logic [2:0] {
    Fmt8  = 3'd0,
    Fmt15 = 3'd1,
    Fmt16 = 3'd2,
    Fmt24 = 3'd3,
    Fmt32 = 3'd4
  } fmt_e;

  // per pixel data carried down the pipeline
  typedef struct packed {
    logic                 mode;
    logic [DepthBits-1:0] owner;
    logic                 map_ok;
    logic                 flush_ok;
    logic [ColorW-1:0]    argb;
  } pix_t;

  // stored owner value of a layer depth
  function automatic logic [DepthBits-1:0] owner_of(logic [DepthW-1:0] d);
    logic [15:0] dx;
    dx = 16'(d);
    return dx[DepthBits-1:0];
  endfunction

  // formats that produce a result
  function automatic logic fmt_valid(logic [2:0] fmt);
    logic ok;
    unique case (fmt)
      Fmt8, Fmt15, Fmt16, Fmt24, Fmt32: ok = 1'b1;
      default:                          ok = 1'b0;
    endcase
    return ok;
  endfunction

  // argb to frame buffer value, low bits used
  function automatic logic [ColorW-1:0] convert_pixel(logic [2:0] fmt, logic [ColorW-1:0] c);
    logic [ColorW-1:0] v;
    unique case (fmt)
      Fmt8:    v = 32'({c[23:21], c[15:13], c[7:6]});
      Fmt15:   v = 32'({c[23:19], c[15:11], c[7:3]});
      Fmt16:   v = 32'({c[23:19], c[15:10], c[7:3]});
      Fmt24:   v = 32'(c[23:0]);
      Fmt32:   v = c;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ design/layer_owner_map_compositor_unit.sv @@
// layer ownership compositor: clipping, ownership store read-modify-write, flush output
// depends on lomc_pkg
//
// a result passes the stage 1, stage 2 and output registers (three register stages)
// throughput: one pixel per cycle unless stalled; separate owner memory read and write ports
// output register freezes the pipeline only while it is full and stalled
// reset: config goes to 1024x768 32bpp; the owner memory is then cleared one entry per
// cycle over all MapEntries (1048576) entries with in_stall_o high; config writes still taken

module layer_owner_map_compositor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_wdata_i,

  // input pixel channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [12:0] pos_x_i,
  input  logic [12:0] pos_y_i,
  input  logic [7:0]  layer_depth_i,
  input  logic [31:0] pixel_argb_i,
  input  logic [7:0]  depth_low_i,
  input  logic [7:0]  depth_high_i,
  input  logic [12:0] rect_left_i,
  input  logic [12:0] rect_top_i,
  input  logic [12:0] rect_right_i,
  input  logic [12:0] rect_bottom_i,

  // output pixel channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] pixel_index_o,
  output logic [31:0] pixel_value_o
);

  localparam int unsigned AW = lomc_pkg::AddrW;
  localparam int unsigned DW = lomc_pkg::DepthBits;

  // configuration registers
  logic [12:0] width_q, height_q;
  logic [2:0]  format_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1024;
      height_q <= 13'd768;
      format_q <= lomc_pkg::Fmt32;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lomc_pkg::RegWidth:  width_q  <= cfg_wdata_i;
        lomc_pkg::RegHeight: height_q <= cfg_wdata_i;
        lomc_pkg::RegFormat: format_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // clearing pass over the owner memory after reset
  logic          clr_active_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      if (clr_addr_q == AW'(lomc_pkg::MapEntries - 1)) begin
        clr_active_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  // pipeline advance and input handshake
  logic out_valid_q;
  logic en;
  logic accept;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_active_q || !en;
  assign accept     = in_valid_i && !in_stall_o;

  // stage 0: screen and rectangle clip, depth tests, row product
  logic [12:0] right_c, bottom_c;
  logic        x_ok, y_ok, clip_ok;
  lomc_pkg::pix_t pix_d;

  always_comb begin
    right_c  = (rect_right_i > width_q) ? width_q : rect_right_i;
    bottom_c = (rect_bottom_i > height_q) ? height_q : rect_bottom_i;
    x_ok     = !pos_x_i[12] && (pos_x_i < width_q) && (pos_x_i >= rect_left_i)
               && (pos_x_i < right_c);
    y_ok     = !pos_y_i[12] && (pos_y_i < height_q) && (pos_y_i >= rect_top_i)
               && (pos_y_i < bottom_c);
    clip_ok  = x_ok && y_ok;

    pix_d.mode     = mode_i;
    pix_d.owner    = lomc_pkg::owner_of(layer_depth_i);
    pix_d.map_ok   = (pixel_argb_i[31:24] != 8'd0) && (layer_depth_i >= depth_low_i);
    pix_d.flush_ok = (layer_depth_i >= depth_low_i) && (layer_depth_i <= depth_high_i);
    pix_d.argb     = pixel_argb_i;
  end

  // stage 1 registers
  logic                          s1_valid_q;
  lomc_pkg::pix_t                s1_pix_q;
  logic [lomc_pkg::ProdW-1:0]    s1_prod_q;
  logic [11:0]                   s1_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept && clip_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pix_q  <= pix_d;
      s1_prod_q <= lomc_pkg::ProdW'(pos_y_i[11:0]) * lomc_pkg::ProdW'(width_q);
      s1_x_q    <= pos_x_i[11:0];
    end
  end

  // stage 1: frame index, store range check, memory read address
  logic [lomc_pkg::SumW-1:0]   s1_sum;
  logic                        s1_in_store;
  logic [lomc_pkg::IndexW-1:0] s1_index;
  logic [AW-1:0]               rd_addr;

  always_comb begin
    s1_sum      = lomc_pkg::SumW'(s1_prod_q) + lomc_pkg::SumW'(s1_x_q);
    s1_in_store = s1_sum < lomc_pkg::SumW'(lomc_pkg::MapEntries);
    s1_index    = s1_sum[lomc_pkg::IndexW-1:0];
    rd_addr     = s1_index[AW-1:0];
  end

  // stage 2 registers
  logic                        s2_valid_q;
  lomc_pkg::pix_t              s2_pix_q;
  logic [lomc_pkg::IndexW-1:0] s2_index_q;
  logic [AW-1:0]               s2_addr;
  logic                        s2_wr;

  assign s2_addr = s2_index_q[AW-1:0];
  assign s2_wr   = s2_valid_q && !s2_pix_q.mode && s2_pix_q.map_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q && s1_in_store;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_pix_q   <= s1_pix_q;
      s2_index_q <= s1_index;
    end
  end

  // owner memory, one write and one registered read per cycle
  logic [DW-1:0] owner_mem_q [lomc_pkg::MapEntries];
  logic [DW-1:0] rd_owner_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;

  always_comb begin
    mem_we    = clr_active_q || (en && s2_wr);
    mem_waddr = clr_active_q ? clr_addr_q : s2_addr;
    mem_wdata = clr_active_q ? '0 : s2_pix_q.owner;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      owner_mem_q[mem_waddr] <= mem_wdata;
    end
    if (en) begin
      rd_owner_q <= owner_mem_q[rd_addr];
    end
  end

  // forward a write that lands in the same cycle as the read of the next pixel
  logic          fwd_q;
  logic [DW-1:0] fwd_owner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (en) begin
      fwd_q <= s2_wr && (s2_addr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fwd_owner_q <= s2_pix_q.owner;
    end
  end

  // stage 2: ownership test and format conversion
  logic [DW-1:0] cur_owner;
  logic          emit;

  always_comb begin
    cur_owner = fwd_q ? fwd_owner_q : rd_owner_q;
    emit      = s2_valid_q && s2_pix_q.mode && s2_pix_q.flush_ok
                && (cur_owner == s2_pix_q.owner) && lomc_pkg::fmt_valid(format_q);
  end

  // output register
  logic [23:0] pixel_index_q;
  logic [31:0] pixel_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && emit) begin
      pixel_index_q <= s2_index_q;
      pixel_value_q <= lomc_pkg::convert_pixel(format_q, s2_pix_q.argb);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = pixel_index_q;
  assign pixel_value_o = pixel_value_q;

  // no pixel in flight while the memory is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> (!s1_valid_q && !s2_valid_q && !out_valid_q))
    else $error("pixel in pipeline during owner memory clear");

  // the clearing pass runs once after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_active_q |=> !clr_active_q)
    else $error("owner memory clear restarted");

  // an emitted index always lies inside the owner store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (lomc_pkg::SumW'(pixel_index_o) < lomc_pkg::SumW'(lomc_pkg::MapEntries)))
    else $error("emitted pixel index outside the owner store");

endmodule
